// File: rtl/jeo_pkg.sv
// Shared types and constants of the Josephus elimination order block.
package jeo_pkg;

   // Widths of the configuration registers.
   localparam int PEOPLE_W = 9;
   localparam int STEP_W   = 20;

   // Configuration port index and data widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = STEP_W;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PEOPLE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_COUNT   = 2'd1;

   // Register reset values.
   localparam logic [PEOPLE_W-1:0] PEOPLE_RESET = 9'd7;
   localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd2;

   // Current configuration as seen by the sequencer.
   typedef struct packed {
      logic [PEOPLE_W-1:0] people_count;
      logic [STEP_W-1:0]   step_count;
   } cfg_type;

endpackage

// File: rtl/jeo_csr.sv
// Configuration registers of the Josephus elimination order block.
module jeo_csr
   import jeo_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [PEOPLE_W-1:0] people_ff;
   logic [PEOPLE_W-1:0] people_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;

   // Decode a write; indexes beyond the list leave both registers alone.
   always_comb begin
      people_in = people_ff;
      step_in   = step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PEOPLE_COUNT: people_in = csr_wdata[PEOPLE_W-1:0];
            CSR_STEP_COUNT:   step_in   = csr_wdata[STEP_W-1:0];
            default: begin
               people_in = people_ff;
               step_in   = step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         people_ff <= PEOPLE_RESET;
         step_ff   <= STEP_RESET;
      end else begin
         people_ff <= people_in;
         step_ff   <= step_in;
      end
   end

   assign cfg.people_count = people_ff;
   assign cfg.step_count   = step_ff;

endmodule

// File: rtl/jeo_link_ram.sv
// Next-link table: one write port and one registered read port.
module jeo_link_ram #(
   parameter int MAX_PEOPLE = 256,
   parameter int PERSON_W   = 9
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PERSON_W-1:0] wr_addr,
   input  logic [PERSON_W-1:0] wr_data,
   input  logic [PERSON_W-1:0] rd_addr,
   output logic [PERSON_W-1:0] rd_data
);

   logic [PERSON_W-1:0] mem [0:MAX_PEOPLE];
   logic [PERSON_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, read every cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/josephus_elimination_order.sv
// On restart the circle is first rebuilt, one link per person up to n
// (n = saturated people_count). Elimination then checks the circle, makes k-1 link
// reads and the unlink (k = step_count, zero taken as one); the result follows.
// A new item is taken only once the last result is taken; one link read per cycle.
// Reset (synchronous, active high) empties the circle and loads people 7, step 2;
// the link table is left as it is and is written by the next restart.
// Top level of the Josephus elimination order block.
module josephus_elimination_order
   import jeo_pkg::*;
#(
   parameter int MAX_PEOPLE = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [$clog2(MAX_PEOPLE+1)-1:0]     rsp_removed_person,
   output logic                                rsp_is_last,
   output logic                                rsp_exhausted,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_INDEX_W-1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_wdata
);

   localparam int PERSON_W = $clog2(MAX_PEOPLE + 1);
   localparam int CMP_W    = (PERSON_W > PEOPLE_W) ? PERSON_W : PEOPLE_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BUILD = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [PERSON_W-1:0] PERSON_ONE = PERSON_W'(1);

   cfg_type cfg;

   logic [2:0]          state_ff, state_in;
   logic [PERSON_W-1:0] cursor_ff, cursor_in;
   logic [PERSON_W-1:0] behind_ff, behind_in;
   logic [PERSON_W-1:0] left_ff, left_in;
   logic [PERSON_W-1:0] size_ff, size_in;
   logic [PERSON_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0]   walk_ff, walk_in;
   logic [PERSON_W-1:0] removed_ff, removed_in;
   logic                is_last_ff, is_last_in;
   logic                exhausted_ff, exhausted_in;

   logic                wr_en;
   logic [PERSON_W-1:0] wr_addr;
   logic [PERSON_W-1:0] wr_data;
   logic [PERSON_W-1:0] rd_addr;
   logic [PERSON_W-1:0] rd_data;

   logic [CMP_W-1:0]    people_ext;
   logic [PERSON_W-1:0] size_sat;

   jeo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jeo_link_ram #(
      .MAX_PEOPLE (MAX_PEOPLE),
      .PERSON_W   (PERSON_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;

   // Circle size, saturated to MAX_PEOPLE.
   always_comb begin
      people_ext = CMP_W'(cfg.people_count);
      if (people_ext > CMP_W'(MAX_PEOPLE)) begin
         size_sat = PERSON_W'(MAX_PEOPLE);
      end else begin
         size_sat = people_ext[PERSON_W-1:0];
      end
   end

   // Sequencer: rebuild, check, walk the links one per cycle, unlink, deliver.
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      behind_in    = behind_ff;
      left_in      = left_ff;
      size_in      = size_ff;
      idx_in       = idx_ff;
      walk_in      = walk_ff;
      removed_in   = removed_ff;
      is_last_in   = is_last_ff;
      exhausted_in = exhausted_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = PERSON_ONE;
      rd_addr      = cursor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  size_in = size_sat;
                  idx_in  = PERSON_ONE;
                  if (size_sat == '0) begin
                     cursor_in = '0;
                     behind_in = '0;
                     left_in   = '0;
                     state_in  = ST_CHECK;
                  end else begin
                     state_in = ST_BUILD;
                  end
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_BUILD: begin
            // Link person idx to the next one, the last one back to person 1.
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = (idx_ff == size_ff) ? PERSON_ONE : idx_ff + PERSON_ONE;
            if (idx_ff == size_ff) begin
               cursor_in = PERSON_ONE;
               behind_in = size_ff;
               left_in   = size_ff;
               state_in  = ST_CHECK;
            end else begin
               idx_in = idx_ff + PERSON_ONE;
            end
         end

         ST_CHECK: begin
            // The read of the cursor's link is issued here.
            rd_addr = cursor_ff;
            if (left_ff == '0) begin
               removed_in   = '0;
               is_last_in   = 1'b0;
               exhausted_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               walk_in  = (cfg.step_count == '0) ? '0 : cfg.step_count - STEP_W'(1);
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            // rd_data holds the link of the current cursor.
            if (walk_ff == '0) begin
               wr_en        = 1'b1;
               wr_addr      = behind_ff;
               wr_data      = rd_data;
               removed_in   = cursor_ff;
               is_last_in   = (left_ff == PERSON_ONE);
               exhausted_in = 1'b0;
               cursor_in    = rd_data;
               left_in      = left_ff - PERSON_ONE;
               state_in     = ST_OUT;
            end else begin
               rd_addr   = rd_data;
               behind_in = cursor_ff;
               cursor_in = rd_data;
               walk_in   = walk_ff - STEP_W'(1);
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         behind_ff <= '0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         behind_ff <= behind_in;
         left_ff   <= left_in;
      end
   end

   // Work and result registers.
   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      idx_ff       <= idx_in;
      walk_ff      <= walk_in;
      removed_ff   <= removed_in;
      is_last_ff   <= is_last_in;
      exhausted_ff <= exhausted_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_removed_person = removed_ff;
   assign rsp_is_last        = is_last_ff;
   assign rsp_exhausted      = exhausted_ff;

endmodule

// File: rtl/jeo_checker.sv
// Port checker of the Josephus elimination order block, with its bind.
module jeo_checker #(
   parameter int MAX_PEOPLE = 256
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [$clog2(MAX_PEOPLE+1)-1:0]   rsp_removed_person,
   input logic                              rsp_is_last,
   input logic                              rsp_exhausted
);

   // An exhausted item names nobody and is never the last removal.
   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> rsp_removed_person == '0 && !rsp_is_last)
      else $error("exhausted item carries a person");

   // Only one item is in work: never ready while a result is shown.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while a result is pending");

   // An accepted item closes the input until its result is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting an item");

   // Exactly one result per item.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("second result after delivery");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_person)
         && $stable(rsp_is_last) && $stable(rsp_exhausted))
      else $error("result changed while stalled");

endmodule

bind josephus_elimination_order jeo_checker #(
   .MAX_PEOPLE (MAX_PEOPLE)
) u_jeo_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_removed_person (rsp_removed_person),
   .rsp_is_last        (rsp_is_last),
   .rsp_exhausted      (rsp_exhausted)
);
